### design/rpn_pkg.sv
// Package for the RPN stack evaluator: widths, action codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;
  localparam int VAL_W = 48;
  localparam int FRAC_BITS = 16;
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int ACT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_DIV   = 3'd4,
    ACT_MOD   = 3'd5,
    ACT_PRINT = 3'd6,
    ACT_UNK   = 3'd7
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [VAL_W-1:0]   number_value;
  } cmd_t;

  typedef struct packed {
    logic             has_value;
    logic [VAL_W-1:0] value;
    logic             stack_overflow;
    logic             stack_underflow;
    logic             zero_divide;
    logic             unknown_command;
  } res_t;

  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};
endpackage

### design/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/rpn_front.sv
// Front end: accepts tokens and holds them in a two-entry queue.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpn_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output rpn_pkg::cmd_t q_cmd
);
  import rpn_pkg::*;
  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        buf_r[wp_r] <= in_cmd;
        wp_r <= ~wp_r;
      end
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

### design/rpn_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rpn_pkg::VAL_W+15:0]    dividend,
  input  logic [rpn_pkg::VAL_W-1:0]     divisor,
  output logic                          done,
  output logic [rpn_pkg::VAL_W+15:0]    quotient,
  output logic [rpn_pkg::VAL_W-1:0]     remainder
);
  import rpn_pkg::*;
  localparam int DW = VAL_W + FRAC_BITS;
  logic [DW-1:0]    q_r;
  logic [VAL_W:0]   rem_r;
  logic [VAL_W-1:0] d_r;
  logic [6:0]       cnt_r;
  logic             busy_r;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;

  assign trial = {rem_r[VAL_W-1:0], q_r[DW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign quotient  = q_r;
  assign remainder = rem_r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r <= dividend; d_r <= divisor; rem_r <= '0;
        cnt_r <= 7'(DW); busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[VAL_W]) begin
          rem_r <= diff; q_r <= {q_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= trial; q_r <= {q_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

### design/rpn_back.sv
// Back end: stack sequencer, arithmetic and output register.
// Depends on rpn_pkg, rpn_ram, rpn_div.
`timescale 1ns / 1ps
module rpn_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  rpn_pkg::cmd_t q_cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output rpn_pkg::res_t res
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_B, S_GET_B, S_RD_A, S_GET_A, S_MUL1, S_MUL2, S_MUL3,
    S_DIV, S_DIVW, S_PUSH, S_OUT
  } state_t;

  state_t            state_r;
  action_t           act_r;
  logic [CNT_W-1:0]  sp_r;
  logic [VAL_W-1:0]  a_r, b_r, r_r;
  logic              under_r, zdiv_r, dopush_r, neg_r, over_r;
  logic [63:0]       pll_r, plh_r, phl_r, phh_r;
  logic [95:0]       prod_r;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [VAL_W-1:0]  wdata, rdata;
  logic              dstart, ddone;
  logic [VAL_W+15:0] ddend, dquo;
  logic [VAL_W-1:0]  dsor, drem;

  rpn_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  rpn_div u_div (
    .clk, .rst_n, .start(dstart), .dividend(ddend), .divisor(dsor),
    .done(ddone), .quotient(dquo), .remainder(drem)
  );

  logic [VAL_W-1:0] mag_a, mag_b, ia, ib;
  assign mag_a = a_r[VAL_W-1] ? -a_r : a_r;
  assign mag_b = b_r[VAL_W-1] ? -b_r : b_r;
  assign ia = {16'd0, mag_a[VAL_W-1:FRAC_BITS]};
  assign ib = {16'd0, mag_b[VAL_W-1:FRAC_BITS]};
  assign raddr = ADDR_W'(sp_r - CNT_W'(1));
  assign q_ready = (state_r == S_IDLE);

  logic [VAL_W:0] sum;
  logic [VAL_W:0] sum_mag;
  assign sum = (act_r == ACT_ADD) ? {a_r[VAL_W-1], a_r} + {b_r[VAL_W-1], b_r}
                                  : {a_r[VAL_W-1], a_r} - {b_r[VAL_W-1], b_r};
  assign sum_mag = sum[VAL_W] ? -sum : sum;

  function automatic logic [VAL_W-1:0] sat(input logic neg, input logic [63:0] m);
    if (neg) sat = (m > 64'(NEG_MIN)) ? NEG_MIN : -m[VAL_W-1:0];
    else     sat = (m > 64'(POS_MAX)) ? POS_MAX : m[VAL_W-1:0];
  endfunction

  always_comb begin
    we = (state_r == S_PUSH) && dopush_r && (sp_r != CNT_W'(STACK_DEPTH));
    waddr = sp_r[ADDR_W-1:0];
    wdata = r_r;
    dstart = (state_r == S_DIV);
    ddend = (act_r == ACT_DIV) ? {mag_a, 16'd0} : {16'd0, ia};
    dsor  = (act_r == ACT_DIV) ? mag_b : ib;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sp_r <= '0; res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state_r != S_OUT) res_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (q_valid) begin
          act_r <= q_cmd.action; under_r <= 1'b0; zdiv_r <= 1'b0;
          dopush_r <= 1'b0; over_r <= 1'b0; a_r <= '0; b_r <= '0;
          case (q_cmd.action)
            ACT_PUSH: begin
              r_r <= q_cmd.number_value; dopush_r <= 1'b1; state_r <= S_PUSH;
            end
            ACT_UNK: state_r <= S_PUSH;
            default: state_r <= S_RD_B;
          endcase
        end
        S_RD_B: begin
          if (sp_r == '0) begin
            under_r <= 1'b1; state_r <= S_GET_B;
          end else state_r <= S_GET_B;
        end
        S_GET_B: begin
          if (sp_r != '0) begin
            b_r <= rdata; sp_r <= sp_r - CNT_W'(1);
          end
          state_r <= (act_r == ACT_PRINT) ? S_PUSH : S_RD_A;
        end
        S_RD_A: begin
          if ((act_r == ACT_DIV && b_r == '0) ||
              (act_r == ACT_MOD && ib == '0)) begin
            zdiv_r <= 1'b1; state_r <= S_PUSH;
          end else begin
            if (sp_r == '0) under_r <= 1'b1;
            state_r <= S_GET_A;
          end
        end
        S_GET_A: begin
          if (sp_r != '0) begin
            a_r <= rdata; sp_r <= sp_r - CNT_W'(1);
          end
          case (act_r)
            ACT_ADD, ACT_SUB: state_r <= S_MUL3;
            ACT_MUL: state_r <= S_MUL1;
            default: state_r <= S_DIV;
          endcase
        end
        S_MUL1: begin
          pll_r <= 64'(mag_a[31:0]) * 64'(mag_b[31:0]);
          plh_r <= 64'(mag_a[31:0]) * 64'(mag_b[VAL_W-1:32]);
          phl_r <= 64'(mag_a[VAL_W-1:32]) * 64'(mag_b[31:0]);
          phh_r <= 64'(mag_a[VAL_W-1:32]) * 64'(mag_b[VAL_W-1:32]);
          neg_r <= a_r[VAL_W-1] ^ b_r[VAL_W-1];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r <= 96'(pll_r) + (96'(plh_r) << 32) + (96'(phl_r) << 32)
                  + (96'(phh_r) << 64);
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          if (act_r == ACT_MUL)
            r_r <= sat(neg_r, (prod_r[95:80] != '0) ? '1 : prod_r[79:16]);
          else
            r_r <= sat(sum[VAL_W], 64'(sum_mag));
          dopush_r <= 1'b1; state_r <= S_PUSH;
        end
        S_DIV: begin
          neg_r <= (act_r == ACT_DIV) ? (a_r[VAL_W-1] ^ b_r[VAL_W-1]) : a_r[VAL_W-1];
          state_r <= S_DIVW;
        end
        S_DIVW: if (ddone) begin
          if (act_r == ACT_DIV) r_r <= sat(neg_r, 64'(dquo));
          else r_r <= sat(neg_r, {drem[47:0], 16'd0});
          dopush_r <= 1'b1; state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (we) sp_r <= sp_r + CNT_W'(1);
          over_r <= dopush_r && (sp_r == CNT_W'(STACK_DEPTH));
          state_r <= S_OUT;
        end
        S_OUT: if (!res_valid || res_ready) begin
          res.has_value <= (act_r == ACT_PRINT);
          res.value <= (act_r == ACT_PRINT) ? b_r : '0;
          res.stack_overflow <= over_r;
          res.stack_underflow <= under_r;
          res.zero_divide <= zdiv_r;
          res.unknown_command <= (act_r == ACT_UNK);
          res_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### design/rpn_stack_evaluator_top.sv
// Top level of the RPN stack evaluator: token queue, sequencer and divider.
// Depends on rpn_pkg, rpn_front, rpn_back.
`timescale 1ns / 1ps
// Usage:
//   in_ channel carries one token word: tuser = action, tdata = number_value.
//   out_ channel returns exactly one result word per token.
//   A two-word queue decouples acceptance from the stack sequencer.
//   Multiply forms four partial products (operands split at bit 32), then
//   a sum; divide and modulo run the divider, one quotient bit per cycle
//   over 64 bits.
//   The sequencer works on one token at a time; the next token starts the
//   cycle after the previous result is registered.
//   The stack is a 128-entry RAM with registered read; each pop passes
//   through a read state and a capture state (S_RD_x, then S_GET_x).
//   Reset (rst_n low, synchronous) empties the stack and the queue; the
//   stack RAM is not cleared since only written entries are read.
//   If out_tready is low, the finished result waits in the output register
//   and the sequencer holds; the queue keeps taking tokens until full.
module rpn_stack_evaluator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // number_value[47:0]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value[47:0]
  output logic [4:0]  out_tuser   // [0] has_value, [1] stack_overflow, [2] stack_underflow,
                                  // [3] zero_divide, [4] unknown_command
);
  import rpn_pkg::*;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t res;

  assign in_cmd.action = action_t'(in_tuser);
  assign in_cmd.number_value = in_tdata;

  rpn_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );
  rpn_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = res.value;
  assign out_tuser = {res.unknown_command, res.zero_divide, res.stack_underflow,
                      res.stack_overflow, res.has_value};
endmodule

### tb/tb_top.sv
// Testbench for rpn_stack_evaluator_top: directed and random token streams,
// checked word by word against a behavioral stack calculator. Depends on rpn_pkg.
`timescale 1ns / 1ps
module tb_top;
  import rpn_pkg::*;

  typedef struct packed {
    logic             has_value;
    logic [VAL_W-1:0] value;
    logic             ovf;
    logic             unf;
    logic             zdiv;
    logic             unk;
  } calc_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [4:0]  out_tuser;

  rpn_stack_evaluator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  logic signed [VAL_W-1:0] calc_stack [STACK_DEPTH];
  int                      calc_depth;
  calc_res_t               expected_q[$];
  int                      err_cnt;
  longint                  cycle_cnt;
  bit                      stall_en;
  bit                      calc_over, calc_under;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] sat48(bit neg, logic [63:0] mag);
    logic [63:0] m;
    m = mag;
    if (neg) begin
      if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
      return VAL_W'(-m);
    end
    if (m > 64'h7FFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF;
    return m[VAL_W-1:0];
  endfunction

  function automatic logic [63:0] abs64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic void calc_push(logic [VAL_W-1:0] v);
    if (calc_depth < STACK_DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else calc_over = 1;
  endfunction

  function automatic longint calc_pop();
    if (calc_depth > 0) begin
      calc_depth--;
      return longint'(calc_stack[calc_depth]);
    end
    calc_under = 1;
    return 0;
  endfunction

  function automatic calc_res_t eval_token(action_t act, logic [VAL_W-1:0] num);
    calc_res_t r;
    longint a, b;
    logic [127:0] prod;
    logic [63:0] ia, ib, q;
    r = '0;
    calc_over = 0;
    calc_under = 0;
    case (act)
      ACT_PUSH: calc_push(num);
      ACT_ADD, ACT_SUB: begin
        b = calc_pop();
        a = calc_pop();
        a = (act == ACT_ADD) ? a + b : a - b;
        calc_push(sat48(a < 0, abs64(a)));
      end
      ACT_MUL: begin
        b = calc_pop();
        a = calc_pop();
        prod = (128'(abs64(a)) * 128'(abs64(b))) >> FRAC_BITS;
        q = (prod[127:64] != 0) ? '1 : prod[63:0];
        calc_push(sat48((a < 0) != (b < 0), q));
      end
      ACT_DIV: begin
        b = calc_pop();
        if (b == 0) r.zdiv = 1;
        else begin
          a = calc_pop();
          q = (abs64(a) << FRAC_BITS) / abs64(b);
          calc_push(sat48((a < 0) != (b < 0), q));
        end
      end
      ACT_MOD: begin
        b = calc_pop();
        ib = abs64(b) >> FRAC_BITS;
        if (ib == 0) r.zdiv = 1;
        else begin
          a = calc_pop();
          ia = abs64(a) >> FRAC_BITS;
          calc_push(sat48(a < 0, (ia % ib) << FRAC_BITS));
        end
      end
      ACT_PRINT: begin
        r.has_value = 1;
        r.value = VAL_W'(calc_pop());
      end
      default: r.unk = 1;
    endcase
    r.ovf = calc_over;
    r.unf = calc_under;
    return r;
  endfunction

  task automatic random_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 60) return;
    n = (n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_token(action_t act, logic [VAL_W-1:0] num);
    if (stall_en) random_gap();
    expected_q.push_back(eval_token(act, num));
    in_tdata  <= num;
    in_tuser  <= act;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (!stall_en) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) < 7) ||
                       ($urandom_range(0, 30) == 0 && out_tready);
  end

  always @(posedge clk) begin
    calc_res_t want;
    calc_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata, out_tuser[1], out_tuser[2],
             out_tuser[3], out_tuser[4]};
      if (expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected word: %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: exp hv=%0b v=%h ov=%0b un=%0b zd=%0b uk=%0b,",
                      " act hv=%0b v=%h ov=%0b un=%0b zd=%0b uk=%0b"},
                     want.has_value, want.value, want.ovf, want.unf,
                     want.zdiv, want.unk,
                     got.has_value, got.value, got.ovf, got.unf,
                     got.zdiv, got.unk);
        end
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_num();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return NEG_MIN;
      2: return VAL_W'($urandom_range(0, 20)) << FRAC_BITS;
      3: return -(VAL_W'($urandom_range(0, 20)) << FRAC_BITS);
      4: return VAL_W'($signed($urandom()));
      default: return VAL_W'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic test_directed();
    send_token(ACT_PRINT, '0);
    send_token(ACT_ADD, '0);
    send_token(ACT_PUSH, POS_MAX);
    send_token(ACT_PUSH, POS_MAX);
    send_token(ACT_ADD, '0);
    send_token(ACT_PUSH, NEG_MIN);
    send_token(ACT_MUL, '0);
    send_token(ACT_PUSH, 48'h1_8000);
    send_token(ACT_DIV, '0);
    send_token(ACT_PUSH, '0);
    send_token(ACT_DIV, '0);
    send_token(ACT_PUSH, 48'h8000);
    send_token(ACT_MOD, '0);
    send_token(ACT_PUSH, -48'sh7_0000);
    send_token(ACT_PUSH, 48'h3_0000);
    send_token(ACT_MOD, '0);
    send_token(ACT_PUSH, NEG_MIN);
    send_token(ACT_SUB, '0);
    send_token(ACT_UNK, 48'hFFFF_FFFF_FFFF);
    send_token(ACT_PRINT, '0);
    send_token(ACT_PRINT, '0);
    send_token(ACT_PRINT, '0);
  endtask

  task automatic test_overflow();
    repeat (STACK_DEPTH + 3) send_token(ACT_PUSH, rand_num());
    repeat (STACK_DEPTH + 2) send_token(ACT_PRINT, '0);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed expression: push a few operands, fold with operators
        k = $urandom_range(2, 5);
        repeat (k) send_token(ACT_PUSH, rand_num());
        repeat (k - 1) send_token(action_t'($urandom_range(1, 5)), '0);
        send_token(ACT_PRINT, '0);
        sent += 2 * k;
      end else begin
        send_token(action_t'($urandom_range(0, 7)), VAL_W'({$urandom(), $urandom()}));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    calc_depth = 0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    stall_en   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_en = 1'b1;
    test_overflow();
    stall_en = 1'b0;
    test_random(300);
    stall_en = 1'b1;
    test_random(700);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
